[rtl/core/range_sum_segment_tree_core_macros.svh]
// Assertion macros for the checker file of this block.
`ifndef RANGE_SUM_SEGMENT_TREE_CORE_MACROS_SVH
`define RANGE_SUM_SEGMENT_TREE_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RSST_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RSST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/rsst_pkg.sv]
`default_nettype none

package rsst_pkg;

    localparam int KIND_W     = 1;
    localparam int POS_W      = 10;
    localparam int IDX_W      = 11;
    localparam int TOTAL_W    = 42;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [KIND_W-1:0] KIND_UPDATE = 1'b0;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 1'b1;

    localparam logic REG_USED_SIZE = 1'b0;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DOWN,
        ST_UP,
        ST_WALK,
        ST_DRAIN,
        ST_RESULT
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLEAR,
        OP_DOWN,
        OP_UP,
        OP_WALK
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   clr_init;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic leaf;
        logic root;
        logic up_last;
        logic walk_done;
        logic query_in;
        logic bad_in;
    } t_status;

endpackage

`default_nettype wire

[rtl/core/rsst_in_if.sv]
`default_nettype none

interface rsst_in_if import rsst_pkg::*; #(
    parameter int VALUE_BITS = 32
) ();
    logic                         valid;
    logic                         ready;
    logic [KIND_W-1:0]            kind;
    logic [POS_W-1:0]             position;
    logic signed [VALUE_BITS-1:0] new_value;
    logic [POS_W-1:0]             range_first;
    logic [POS_W-1:0]             range_last;

    modport source (
        output valid, kind, position, new_value, range_first, range_last,
        input  ready
    );

    modport sink (
        input  valid, kind, position, new_value, range_first, range_last,
        output ready
    );
endinterface

`default_nettype wire

[rtl/core/rsst_out_if.sv]
`default_nettype none

interface rsst_out_if import rsst_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [TOTAL_W-1:0] range_total;
    logic                      bad_index;

    modport source (
        output valid, range_total, bad_index,
        input  ready
    );

    modport sink (
        input  valid, range_total, bad_index,
        output ready
    );
endinterface

`default_nettype wire

[rtl/core/rsst_ram.sv]
`default_nettype none

module rsst_ram #(
    parameter int WIDTH = 42,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

`default_nettype wire

[rtl/core/rsst_ctrl.sv]
`default_nettype none

module rsst_ctrl import rsst_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_cfg_wr,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire logic    i_out_ready,
    output logic         o_out_valid,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);
    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign w_accept = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_status.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_status.query_in)    n_state = ST_WALK;
                    else if (i_status.bad_in) n_state = ST_RESULT;
                    else                      n_state = ST_DOWN;
                end
            end
            ST_DOWN: begin
                if (i_status.leaf) begin
                    n_state = i_status.root ? ST_RESULT : ST_UP;
                end
            end
            ST_UP: begin
                if (i_status.up_last) n_state = ST_RESULT;
            end
            ST_WALK: begin
                if (i_status.walk_done) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                n_state = ST_RESULT;
            end
            ST_RESULT: begin
                if (i_out_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
        // A new used size reshapes the tree, so the store is swept again.
        if (i_cfg_wr) n_state = ST_CLEAR;
    end

    always_comb begin
        o_cmd.op       = OP_NONE;
        o_cmd.clr_init = i_cfg_wr;
        o_in_ready     = 1'b0;
        o_out_valid    = 1'b0;
        unique case (r_state)
            ST_CLEAR: o_cmd.op = OP_CLEAR;
            ST_IDLE: begin
                o_in_ready = !i_cfg_wr;
                if (w_accept) o_cmd.op = OP_LOAD;
            end
            ST_DOWN:   o_cmd.op = OP_DOWN;
            ST_UP:     o_cmd.op = OP_UP;
            ST_WALK:   o_cmd.op = OP_WALK;
            ST_DRAIN:  o_cmd.op = OP_NONE;
            ST_RESULT: o_out_valid = 1'b1;
            default:   o_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

`default_nettype wire

[rtl/core/rsst_dp.sv]
`default_nettype none

module rsst_dp import rsst_pkg::*; #(
    parameter int LEAVES     = 1024,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire t_cmd                         i_cmd,
    output t_status                           o_status,
    input  wire logic [IDX_W-1:0]             i_used_size,
    input  wire logic [KIND_W-1:0]            i_kind,
    input  wire logic [POS_W-1:0]             i_position,
    input  wire logic signed [VALUE_BITS-1:0] i_new_value,
    input  wire logic [POS_W-1:0]             i_range_first,
    input  wire logic [POS_W-1:0]             i_range_last,
    output logic signed [TOTAL_W-1:0]         o_range_total,
    output logic                              o_bad_index
);
    localparam int DEPTH  = 2 * LEAVES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int STK_D  = $clog2(LEAVES) + 1;
    localparam int SI_W   = $clog2(STK_D);
    localparam int SP_W   = $clog2(STK_D + 1);
    localparam logic [ADDR_W:0]   DEPTH_L  = (ADDR_W + 1)'(DEPTH);
    localparam logic [ADDR_W-1:0] ROOT     = ADDR_W'(1);
    localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(DEPTH - 1);

    typedef struct packed {
        logic [ADDR_W-1:0] node;
        logic [IDX_W-1:0]  l;
        logic [IDX_W-1:0]  r;
    } t_frame;

    // Control registers.
    logic              r_pend, n_pend;
    logic [ADDR_W-1:0] r_clr_addr, n_clr_addr;
    logic [SP_W-1:0]   r_sp, n_sp;
    // Working registers of the walk.
    logic [ADDR_W-1:0]  r_v, n_v;
    logic [IDX_W-1:0]   r_l, n_l;
    logic [IDX_W-1:0]   r_r, n_r;
    logic [IDX_W-1:0]   r_pos, n_pos;
    logic [IDX_W-1:0]   r_lo, n_lo;
    logic [IDX_W-1:0]   r_hi, n_hi;
    logic [TOTAL_W-1:0] r_val, n_val;
    logic [TOTAL_W-1:0] r_total, n_total;
    logic               r_bad, n_bad;
    t_frame             r_stk [STK_D];

    logic               w_we;
    logic [ADDR_W-1:0]  w_waddr;
    logic [TOTAL_W-1:0] w_wdata;
    logic [ADDR_W-1:0]  w_raddr;
    logic [TOTAL_W-1:0] w_rdata;

    logic [IDX_W-1:0]   w_top;
    logic [IDX_W-1:0]   w_mid;
    logic               w_leaf;
    logic               w_v_ok;
    logic [ADDR_W-1:0]  w_par;
    logic               w_par_ok;
    logic [ADDR_W-1:0]  w_sib;
    logic               w_sib_ok;
    logic               w_disj;
    logic               w_cont;
    logic [TOTAL_W-1:0] w_sum;
    logic [SP_W-1:0]    w_sp_dec;
    t_frame             w_pop;
    t_frame             w_push_frame;
    logic               w_push;
    logic signed [63:0] w_ext;

    rsst_ram #(
        .WIDTH (TOTAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_top    = i_used_size - IDX_W'(1);
    assign w_mid    = r_l + ((r_r - r_l) >> 1);
    assign w_leaf   = (r_l == r_r);
    assign w_v_ok   = {1'b0, r_v} < DEPTH_L;
    assign w_par    = r_v >> 1;
    assign w_par_ok = {1'b0, w_par} < DEPTH_L;
    assign w_sib    = r_v ^ ROOT;
    assign w_sib_ok = {1'b0, w_sib} < DEPTH_L;
    assign w_disj   = (r_r < r_lo) || (r_hi < r_l);
    assign w_cont   = (r_lo <= r_l) && (r_r <= r_hi);
    // A child that lies beyond the store reads as zero.
    assign w_sum    = r_val + (w_sib_ok ? w_rdata : '0);
    assign w_sp_dec = r_sp - SP_W'(1);
    assign w_pop    = r_stk[w_sp_dec[SI_W-1:0]];
    assign w_ext    = 64'(i_new_value);

    assign w_push_frame.node = {r_v[ADDR_W-2:0], 1'b1};
    assign w_push_frame.l    = w_mid + IDX_W'(1);
    assign w_push_frame.r    = r_r;

    always_comb begin
        n_pend     = 1'b0;
        n_clr_addr = r_clr_addr;
        n_sp       = r_sp;
        n_v        = r_v;
        n_l        = r_l;
        n_r        = r_r;
        n_pos      = r_pos;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_val      = r_val;
        n_total    = r_pend ? (r_total + w_rdata) : r_total;
        n_bad      = r_bad;
        w_we       = 1'b0;
        w_waddr    = r_v;
        w_wdata    = r_val;
        w_raddr    = r_v;
        w_push     = 1'b0;

        case (i_cmd.op)
            OP_LOAD: begin
                n_v     = ROOT;
                n_l     = '0;
                n_r     = w_top;
                n_sp    = '0;
                n_pos   = {{(IDX_W - POS_W){1'b0}}, i_position};
                n_lo    = {{(IDX_W - POS_W){1'b0}}, i_range_first};
                n_hi    = {{(IDX_W - POS_W){1'b0}}, i_range_last};
                n_val   = w_ext[TOTAL_W-1:0];
                n_total = '0;
                n_bad   = o_status.bad_in;
            end
            OP_CLEAR: begin
                w_we       = 1'b1;
                w_waddr    = r_clr_addr;
                w_wdata    = '0;
                n_clr_addr = r_clr_addr + ADDR_W'(1);
            end
            OP_DOWN: begin
                if (w_leaf) begin
                    w_we    = w_v_ok;
                    n_val   = w_v_ok ? r_val : '0;
                    w_raddr = w_sib;
                end else if (r_pos <= w_mid) begin
                    n_v = {r_v[ADDR_W-2:0], 1'b0};
                    n_r = w_mid;
                end else begin
                    n_v = {r_v[ADDR_W-2:0], 1'b1};
                    n_l = w_mid + IDX_W'(1);
                end
            end
            OP_UP: begin
                // Sibling data arrived; refresh the parent and fetch its sibling.
                w_we    = w_par_ok;
                w_waddr = w_par;
                w_wdata = w_sum;
                n_val   = w_par_ok ? w_sum : '0;
                n_v     = w_par;
                w_raddr = w_par ^ ROOT;
            end
            OP_WALK: begin
                if (w_disj || w_cont) begin
                    n_pend = w_cont && w_v_ok;
                    if (r_sp != '0) begin
                        n_v  = w_pop.node;
                        n_l  = w_pop.l;
                        n_r  = w_pop.r;
                        n_sp = w_sp_dec;
                    end
                end else begin
                    // Defer the right half and go down the left half first.
                    w_push = 1'b1;
                    n_sp   = r_sp + SP_W'(1);
                    n_v    = {r_v[ADDR_W-2:0], 1'b0};
                    n_r    = w_mid;
                end
            end
            default: ;
        endcase

        if (i_cmd.clr_init) n_clr_addr = '0;
    end

    always_comb begin
        o_status.clr_last  = (r_clr_addr == CLR_LAST);
        o_status.leaf      = w_leaf;
        o_status.root      = (r_v == ROOT);
        o_status.up_last   = (w_par == ROOT);
        o_status.walk_done = (w_disj || w_cont) && (r_sp == '0);
        o_status.query_in  = (i_kind == KIND_QUERY);
        o_status.bad_in    = (i_kind == KIND_UPDATE)
                             && ({{(IDX_W - POS_W){1'b0}}, i_position} >= i_used_size);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend     <= 1'b0;
            r_clr_addr <= '0;
            r_sp       <= '0;
        end else begin
            r_pend     <= n_pend;
            r_clr_addr <= n_clr_addr;
            r_sp       <= n_sp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v     <= n_v;
        r_l     <= n_l;
        r_r     <= n_r;
        r_pos   <= n_pos;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_val   <= n_val;
        r_total <= n_total;
        r_bad   <= n_bad;
        if (w_push) begin
            r_stk[r_sp[SI_W-1:0]] <= w_push_frame;
        end
    end

    assign o_range_total = r_total;
    assign o_bad_index   = r_bad;
endmodule

`default_nettype wire

[rtl/core/range_sum_segment_tree_core.sv]
// Update: one descent step per level, then one read-add-write per level on the way
// back up through the node store's two ports.
// Query: one walk step per visited tree node.
// One item is in work at a time; the next is taken once the result word is taken.
// Reset is synchronous; after reset and after every used_size write the node store is
// swept to zero over all 2*LEAVES addresses, during which no input word is taken.
`default_nettype none

module range_sum_segment_tree_core import rsst_pkg::*; #(
    parameter int LEAVES     = 1024,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    rsst_in_if.sink                    i_in,
    rsst_out_if.source                 o_out
);
    localparam int USED_RST = (LEAVES > 2047) ? 2047 : LEAVES;
    localparam logic [IDX_W-1:0] USED_MAX = IDX_W'(USED_RST);

    logic [IDX_W-1:0] r_used_size, n_used_size;
    logic [IDX_W-1:0] w_wr_size;
    logic             w_cfg_wr;
    t_cmd             w_cmd;
    t_status          w_status;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready
                       && (paddr[APB_ADDR_W-1] == REG_USED_SIZE);
    assign w_wr_size = pwdata[IDX_W-1:0];
    assign prdata    = APB_DATA_W'(r_used_size);

    always_comb begin
        if (w_wr_size == '0) begin
            n_used_size = IDX_W'(1);
        end else if (32'(w_wr_size) > 32'(USED_RST)) begin
            n_used_size = USED_MAX;
        end else begin
            n_used_size = w_wr_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used_size <= USED_MAX;
        end else if (w_cfg_wr) begin
            r_used_size <= n_used_size;
        end
    end

    rsst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr    (w_cfg_wr),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    rsst_dp #(
        .LEAVES     (LEAVES),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_used_size   (r_used_size),
        .i_kind        (i_in.kind),
        .i_position    (i_in.position),
        .i_new_value   (i_in.new_value),
        .i_range_first (i_in.range_first),
        .i_range_last  (i_in.range_last),
        .o_range_total (o_out.range_total),
        .o_bad_index   (o_out.bad_index)
    );
endmodule

`default_nettype wire

[rtl/core/rsst_checker.sv]
`default_nettype none

`include "range_sum_segment_tree_core_macros.svh"

module rsst_checker import rsst_pkg::*; (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_psel,
    input wire logic                      i_penable,
    input wire logic                      i_pwrite,
    input wire logic                      i_pready,
    input wire logic                      i_in_valid,
    input wire logic                      i_in_ready,
    input wire logic                      i_out_valid,
    input wire logic                      i_out_ready,
    input wire logic signed [TOTAL_W-1:0] i_range_total,
    input wire logic                      i_bad_index
);
    logic w_cfg_wr;
    logic w_in_take;
    logic w_out_take;

    assign w_cfg_wr   = i_psel && i_penable && i_pwrite && i_pready;
    assign w_in_take  = i_in_valid && i_in_ready;
    assign w_out_take = i_out_valid && i_out_ready;

    // A used_size write starts a sweep of the store, so no word is taken next.
    `RSST_ASSERT_NEXT(a_cfg_blocks_input, i_clk, i_rst_n, w_cfg_wr, !i_in_ready, "input ready right after a configuration write")
    // One item at a time: no new word while a result waits.
    `RSST_ASSERT_NOW(a_no_overlap, i_clk, i_rst_n, i_out_valid, !i_in_ready, "input ready while a result is pending")
    `RSST_ASSERT_NEXT(a_one_result, i_clk, i_rst_n, w_out_take, !i_out_valid, "second result without a new input word")
    `RSST_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, w_in_take, !i_in_ready, "input ready in the cycle after a word was taken")
    `RSST_ASSERT_NOW(a_bad_has_no_sum, i_clk, i_rst_n, i_out_valid && i_bad_index, i_range_total == '0, "flagged update carries a nonzero sum")
endmodule

bind range_sum_segment_tree_core rsst_checker u_rsst_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_psel        (psel),
    .i_penable     (penable),
    .i_pwrite      (pwrite),
    .i_pready      (pready),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_range_total (o_out.range_total),
    .i_bad_index   (o_out.bad_index)
);

`default_nettype wire

[tb/range_sum_segment_tree_core_test.sv]
`timescale 1ns / 100ps

module range_sum_segment_tree_core_test;
    import rsst_pkg::*;

    localparam int LEAVES      = 1024;
    localparam int VALUE_BITS  = 32;
    localparam int STALL_LIMIT = 20000;
    localparam int LONG_HOLD   = 400;

    localparam logic [APB_ADDR_W-1:0] SIZE_ADDR = APB_ADDR_W'(4 * REG_USED_SIZE);

    typedef struct {
        logic [KIND_W-1:0]            kind;
        logic [POS_W-1:0]             position;
        logic signed [VALUE_BITS-1:0] new_value;
        logic [POS_W-1:0]             range_first;
        logic [POS_W-1:0]             range_last;
    } t_word;

    typedef struct {
        logic signed [TOTAL_W-1:0] range_total;
        logic                      bad_index;
    } t_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    rsst_in_if #(.VALUE_BITS(VALUE_BITS)) in_word ();
    rsst_out_if                           out_word ();

    range_sum_segment_tree_core #(
        .LEAVES     (LEAVES),
        .VALUE_BITS (VALUE_BITS)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (in_word),
        .o_out   (out_word)
    );

    // Shadow of the leaves; node sums follow from them.
    longint  leaf_value [LEAVES];
    int      tree_size;

    t_word   pending_words [$];
    t_result expected_results [$];
    t_word   drive_word;
    t_word   taken_word;
    t_result oldest_result;

    logic    in_taken;
    int      stall_cycles;
    int      error_count;
    int      results_seen;
    int      n_updates;
    int      n_queries;
    int      n_flagged;
    int      n_sizes;
    int      burst_left;
    int      gap_left;
    int      hold_left;
    bit      hold_done;
    int      ready_mode;
    int      mode_left;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic void load_size(input logic [APB_DATA_W-1:0] raw);
        int n;
        n = int'(raw[10:0]);
        if (n < 1) n = 1;
        if (n > LEAVES) n = LEAVES;
        tree_size = n;
        foreach (leaf_value[i]) leaf_value[i] = 0;
    endfunction

    function automatic t_result range_sum_result(input t_word w);
        t_result r;
        longint  acc;
        r.range_total = '0;
        r.bad_index   = 1'b0;
        acc = 0;
        if (w.kind == KIND_UPDATE) begin
            if (int'(w.position) >= tree_size) begin
                r.bad_index = 1'b1;
            end else begin
                leaf_value[w.position] = longint'(w.new_value);
            end
        end else begin
            // Empty, clipped and out-of-range queries all fall out of the bounds.
            for (int i = int'(w.range_first); i <= int'(w.range_last) && i < tree_size; i++) begin
                acc += leaf_value[i];
            end
            r.range_total = acc[TOTAL_W-1:0];
        end
        return r;
    endfunction

    task automatic push_update(input int pos, input logic [31:0] val);
        t_word w;
        w.kind        = KIND_UPDATE;
        w.position    = POS_W'(pos);
        w.new_value   = val;
        w.range_first = POS_W'($urandom);
        w.range_last  = POS_W'($urandom);
        pending_words.push_back(w);
    endtask

    task automatic push_query(input int first, input int last);
        t_word w;
        w.kind        = KIND_QUERY;
        w.position    = POS_W'($urandom);
        w.new_value   = $urandom;
        w.range_first = POS_W'(first);
        w.range_last  = POS_W'(last);
        pending_words.push_back(w);
    endtask

    task automatic add_random(input int count);
        t_word w;
        int    pick;
        int    hi;
        int    first;
        hi = tree_size - 1;
        for (int n = 0; n < count; n++) begin
            w.kind        = KIND_QUERY;
            w.position    = POS_W'($urandom);
            w.new_value   = $urandom;
            w.range_first = POS_W'($urandom);
            w.range_last  = POS_W'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                w.kind = KIND_UPDATE;
                if (pick < 5 && tree_size < LEAVES) begin
                    w.position = POS_W'($urandom_range(tree_size, LEAVES - 1));
                end else begin
                    w.position = POS_W'($urandom_range(0, hi));
                end
                case ($urandom_range(0, 9))
                    0: w.new_value = 32'h7FFF_FFFF;
                    1: w.new_value = 32'h8000_0000;
                    2: w.new_value = '0;
                    3: w.new_value = '1;
                    4: w.new_value = $urandom_range(0, 255) - 128;
                    default: ;
                endcase
            end else if (pick < 75) begin
                first = $urandom_range(0, hi);
                w.range_first = POS_W'(first);
                w.range_last  = POS_W'($urandom_range(first, hi));
            end else if (pick < 82) begin
                first = $urandom_range(1, LEAVES - 1);
                w.range_first = POS_W'(first);
                w.range_last  = POS_W'($urandom_range(0, first - 1));
            end else if (pick < 89) begin
                w.range_first = POS_W'($urandom_range(0, hi));
                w.range_last  = POS_W'($urandom_range(hi, LEAVES - 1));
            end else if (pick < 94 && tree_size < LEAVES) begin
                first = $urandom_range(tree_size, LEAVES - 1);
                w.range_first = POS_W'(first);
                w.range_last  = POS_W'($urandom_range(first, LEAVES - 1));
            end
            pending_words.push_back(w);
        end
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || expected_results.size() != 0 || in_word.valid) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_size(input logic [APB_DATA_W-1:0] raw);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SIZE_ADDR;
        pwdata  <= raw;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        load_size(raw);
        n_sizes++;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Sender: bursts of words separated by random gaps.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_word.valid <= 1'b0;
        end else if (!in_word.valid || in_taken) begin
            if (gap_left > 0 || pending_words.size() == 0) begin
                if (gap_left > 0) gap_left--;
                in_word.valid <= 1'b0;
            end else begin
                drive_word = pending_words.pop_front();
                in_word.valid       <= 1'b1;
                in_word.kind        <= drive_word.kind;
                in_word.position    <= drive_word.position;
                in_word.new_value   <= drive_word.new_value;
                in_word.range_first <= drive_word.range_first;
                in_word.range_last  <= drive_word.range_last;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 15);
                    case ($urandom_range(0, 3))
                        0: gap_left = 0;
                        1, 2: gap_left = $urandom_range(1, 3);
                        default: gap_left = $urandom_range(4, 25);
                    endcase
                end
            end
        end
    end

    // Receiver: switches between random stall patterns, with one long hold-off.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            out_word.ready <= 1'b0;
        end else if (!hold_done && results_seen >= 150) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
            out_word.ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                ready_mode = $urandom_range(0, 2);
                mode_left  = $urandom_range(16, 96);
            end
            mode_left--;
            case (ready_mode)
                0: out_word.ready <= 1'b1;
                1: out_word.ready <= 1'($urandom_range(0, 1));
                default: out_word.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= in_word.valid && in_word.ready;
            if ((in_word.valid && in_word.ready) || (out_word.valid && out_word.ready)) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
            if (in_word.valid && in_word.ready) begin
                taken_word.kind        = in_word.kind;
                taken_word.position    = in_word.position;
                taken_word.new_value   = in_word.new_value;
                taken_word.range_first = in_word.range_first;
                taken_word.range_last  = in_word.range_last;
                oldest_result = range_sum_result(taken_word);
                expected_results.push_back(oldest_result);
                if (taken_word.kind == KIND_UPDATE) n_updates++;
                else n_queries++;
                if (oldest_result.bad_index) n_flagged++;
            end
            if (out_word.valid && out_word.ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $error("result word arrived with no expectation pending");
                    error_count++;
                end else begin
                    oldest_result = expected_results.pop_front();
                    if (out_word.range_total !== oldest_result.range_total) begin
                        $error("range_total: expected %0d, got %0d",
                               oldest_result.range_total, out_word.range_total);
                        error_count++;
                    end
                    if (out_word.bad_index !== oldest_result.bad_index) begin
                        $error("bad_index: expected %0b, got %0b",
                               oldest_result.bad_index, out_word.bad_index);
                        error_count++;
                    end
                end
            end
        end
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("range_sum_segment_tree_core_test: errors");
        $finish;
    end

    initial begin
        i_rst_n              = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        in_word.valid        = 1'b0;
        in_word.kind         = KIND_UPDATE;
        in_word.position     = '0;
        in_word.new_value    = '0;
        in_word.range_first  = '0;
        in_word.range_last   = '0;
        out_word.ready       = 1'b0;
        in_taken             = 1'b0;
        stall_cycles         = 0;
        error_count          = 0;
        results_seen         = 0;
        n_updates            = 0;
        n_queries            = 0;
        n_flagged            = 0;
        n_sizes              = 1;
        burst_left           = 0;
        gap_left             = 0;
        hold_left            = 0;
        hold_done            = 1'b0;
        ready_mode           = 0;
        mode_left            = 0;
        load_size(LEAVES);

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Full tree: extreme values and positions whose bits alternate.
        push_query(0, LEAVES - 1);
        push_update(0, 32'h7FFF_FFFF);
        push_update(LEAVES - 1, 32'h8000_0000);
        push_update(512, 32'hFFFF_FFFF);
        push_update(511, 32'h5555_5555);
        push_update(341, 32'hAAAA_AAAA);
        push_update(682, 32'h0000_0001);
        push_query(0, LEAVES - 1);
        push_query(0, 0);
        push_query(LEAVES - 1, LEAVES - 1);
        push_query(LEAVES - 1, 0);
        push_query(511, 512);
        push_query(1, LEAVES - 2);
        push_update(0, 32'h0000_0000);
        push_query(0, 511);
        push_query(300, 700);
        push_query(682, 682);
        add_random(430);
        wait_drained();

        // Single leaf: flagged updates, clipped and out-of-range queries.
        write_size(1);
        push_update(0, 32'h0000_0005);
        push_update(1, 32'h1234_5678);
        push_update(LEAVES - 1, 32'h8765_4321);
        push_query(0, 0);
        push_query(0, LEAVES - 1);
        push_query(1, LEAVES - 1);
        push_query(1, 0);
        push_query(5, 9);
        add_random(60);
        wait_drained();

        // Zero and oversized writes are clamped into range.
        write_size(0);
        add_random(30);
        wait_drained();
        write_size(32'h0000_07FF);
        add_random(150);
        wait_drained();

        write_size(2);
        add_random(60);
        wait_drained();
        write_size(3);
        add_random(60);
        wait_drained();
        write_size(1000);
        add_random(150);
        wait_drained();
        write_size(513);
        add_random(150);
        wait_drained();
        write_size(LEAVES);
        add_random(110);
        wait_drained();
        write_size($urandom_range(4, LEAVES - 1));
        add_random(100);
        wait_drained();

        repeat (60) @(posedge i_clk);
        $display("Checked %0d updates (%0d flagged out of range) and %0d queries",
                 n_updates, n_flagged, n_queries);
        $display("across %0d tree sizes, with a %0d-cycle result hold-off.", n_sizes, LONG_HOLD);
        if (error_count == 0) begin
            $display("range_sum_segment_tree_core_test: clean");
        end else begin
            $display("range_sum_segment_tree_core_test: errors");
        end
        $finish;
    end

endmodule
